### sv/wildcard_name_matcher_unit_defines.svh
// Assertion macros used by the wildcard name matcher RTL.
`ifndef WILDCARD_NAME_MATCHER_UNIT_DEFINES_SVH
`define WILDCARD_NAME_MATCHER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define WNM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define WNM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/wnm_pkg.sv
// Package with the types, constants and helpers of the wildcard name matcher.
`default_nettype none

package wnm_pkg;

  // Mask capacity and the widths that follow from it.
  localparam int MASK_LEN = 32;
  localparam int POS_W    = MASK_LEN + 1;
  localparam int LEN_W    = $clog2(MASK_LEN + 1);
  localparam int IDX_W    = (MASK_LEN > 1) ? $clog2(MASK_LEN) : 1;

  // Byte constants.
  localparam logic [7:0] CH_STAR     = 8'h2A;
  localparam logic [7:0] CH_QMARK    = 8'h3F;
  localparam logic [7:0] CH_DOT      = 8'h2E;
  localparam logic [7:0] CH_UPPER_A  = 8'h41;
  localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  // Kind of an input beat, carried on tuser.
  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_NAME   = 2'd2
  } action_t;

  // One input beat as held in the input register.
  typedef struct packed {
    logic [1:0] action;
    logic [7:0] char_value;
    logic       last;
  } item_t;

  // Mask state as seen by the match logic.
  typedef struct packed {
    logic [MASK_LEN-1:0]      star;      // position holds a live '*'
    logic [MASK_LEN-1:0]      qmark;     // position holds a '?'
    logic [MASK_LEN-1:0]      in_mask;   // position is below the mask length
    logic [MASK_LEN-1:0][7:0] chr;       // folded mask byte
    logic [POS_W-1:0]         start;     // positions reached before any name byte
    logic [LEN_W-1:0]         len;
    logic                     match_all;
    logic                     overflow;
  } mask_view_t;

  // Fold ASCII upper-case letters to lower case.
  function automatic logic [7:0] fold_letter(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
      r = c + CASE_OFFSET;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### sv/wildcard_name_matcher_unit.sv
// Wildcard name matcher top level: input register, mask store, match core, result register.
//
// Usage:
//   The input channel carries one byte per beat: in_tdata is the byte, in_tuser
//   the kind (clear mask, append mask byte, name byte) and in_tlast marks the
//   final byte of a name. Kind 3 is ignored. Mask bytes beyond the capacity
//   are dropped and reported with the next result.
//   The result channel gives one beat per name, on its last byte: bit 0 of
//   out_tdata is the match flag, bit 1 the mask overflow flag.
//   The result of a name is registered. Throughput: one input beat per cycle
//   while no result beat is blocked; the position update of one byte is
//   a single row of byte compares and one carry chain across the positions.
//   When the receiver stalls, one result waits in the output register while
//   the next beat is held in the input register; non-result beats keep
//   flowing until a second result would be needed.
//   Reset (rst_n low at a clock edge) empties both registers, clears the mask
//   and abandons any name in progress; there is no clearing pass.
`default_nettype none
`include "wildcard_name_matcher_unit_defines.svh"

module wildcard_name_matcher_unit (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] char_value
  input  wire logic [1:0] in_tuser,   // [1:0] action
  input  wire logic       in_tlast,   // last
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata   // [0] matched, [1] mask_overflow, [7:2] zero
);
  import wnm_pkg::*;

  logic       s1_v_r, s1_v_nxt;
  item_t      s1_item_r;
  logic       s1_result;
  logic       s1_go;
  logic       in_acc;
  logic       out_v_r, out_v_nxt;
  logic [1:0] out_data_r;
  logic       matched;
  mask_view_t view;

  // Handshake of the input register.
  assign s1_result = s1_v_r && (s1_item_r.action == ACT_NAME) && s1_item_r.last;
  assign s1_go     = s1_v_r && (!s1_result || !out_v_r || out_tready);
  assign in_tready = !s1_v_r || s1_go;
  assign in_acc    = in_tvalid && in_tready;
  assign s1_v_nxt  = in_acc || (s1_v_r && !s1_go);

  // Result register valid.
  always_comb begin
    out_v_nxt = out_v_r;
    if (s1_go && s1_result) begin
      out_v_nxt = 1'b1;
    end else if (out_tready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r.action     <= in_tuser;
      s1_item_r.char_value <= in_tdata;
      s1_item_r.last       <= in_tlast;
    end
    if (s1_go && s1_result) begin
      out_data_r <= {view.overflow, matched};
    end
  end

  wnm_mask_store u_mask (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (s1_go),
    .item (s1_item_r),
    .view (view)
  );

  wnm_match_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .go     (s1_go),
    .item   (s1_item_r),
    .view   (view),
    .matched(matched)
  );

  assign out_tvalid = out_v_r;
  assign out_tdata  = {6'b0, out_data_r};

  // Checks on the internal flow.
  `WNM_ASSERT_SAME(a_ready_when_empty, !s1_v_r, in_tready, "input register empty but not ready")
  `WNM_ASSERT_NEXT(a_blocked_item_held, s1_result && out_v_r && !out_tready, s1_v_r && $stable(s1_item_r), "blocked result beat lost")
  `WNM_ASSERT_SAME(a_result_has_source, $rose(out_v_r), $past(s1_go) && $past(s1_result), "result without a last name beat")
  `WNM_ASSERT_SAME(a_len_in_range, 1'b1, view.len <= LEN_W'(MASK_LEN), "mask length beyond capacity")

endmodule

`default_nettype wire

### sv/wnm_mask_store.sv
// Mask store: loaded mask bytes, length, overflow flag and start positions.
`default_nettype none

module wnm_mask_store (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                go,
  input  wire wnm_pkg::item_t      item,
  output wnm_pkg::mask_view_t      view
);
  import wnm_pkg::*;

  logic [LEN_W-1:0]         len_r, len_nxt;
  logic                     ovf_r, ovf_nxt;
  logic [POS_W-1:0]         start_r, start_nxt;
  logic [MASK_LEN-1:0][7:0] chr_r;
  logic [MASK_LEN-1:0]      star_r;
  logic [MASK_LEN-1:0]      qmark_r;
  logic [MASK_LEN-1:0]      in_mask;
  logic                     has_room;
  logic                     do_write;
  logic                     is_star;
  logic [LEN_W-1:0]         len_inc;
  logic [IDX_W-1:0]         wr_idx;
  logic                     match_all;

  assign has_room = (len_r < LEN_W'(MASK_LEN));
  assign is_star  = (item.char_value == CH_STAR);
  assign len_inc  = len_r + LEN_W'(1);
  assign wr_idx   = len_r[IDX_W-1:0];
  assign do_write = go && (item.action == ACT_APPEND) && has_room;

  // Control state: length, overflow and the leading star run.
  always_comb begin
    len_nxt   = len_r;
    ovf_nxt   = ovf_r;
    start_nxt = start_r;
    if (go) begin
      unique case (item.action)
        ACT_CLEAR: begin
          len_nxt   = '0;
          ovf_nxt   = 1'b0;
          start_nxt = POS_W'(1);
        end
        ACT_APPEND: begin
          if (has_room) begin
            len_nxt = len_inc;
            // A star reached before any name byte extends the start set.
            if (is_star && start_r[len_r]) begin
              start_nxt[len_inc] = 1'b1;
            end
          end else begin
            ovf_nxt = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r   <= '0;
      ovf_r   <= 1'b0;
      start_r <= POS_W'(1);
    end else begin
      len_r   <= len_nxt;
      ovf_r   <= ovf_nxt;
      start_r <= start_nxt;
    end
  end

  // Mask bytes, stored folded and pre-decoded; undefined until written.
  always_ff @(posedge clk) begin
    if (do_write) begin
      chr_r[wr_idx]   <= fold_letter(item.char_value);
      star_r[wr_idx]  <= is_star;
      qmark_r[wr_idx] <= (item.char_value == CH_QMARK);
    end
  end

  // Positions below the current length.
  for (genvar i = 0; i < MASK_LEN; i++) begin : g_in_mask
    assign in_mask[i] = (LEN_W'(i) < len_r);
  end

  // The empty mask and the mask "*.*" match every name.
  if (MASK_LEN >= 3) begin : g_dot_star
    assign match_all = (len_r == '0) ||
                       ((len_r == LEN_W'(3)) && star_r[0] && star_r[2] &&
                        (chr_r[1] == CH_DOT));
  end else begin : g_short
    assign match_all = (len_r == '0);
  end

  assign view.star      = star_r & in_mask;
  assign view.qmark     = qmark_r & in_mask;
  assign view.in_mask   = in_mask;
  assign view.chr       = chr_r;
  assign view.start     = start_r;
  assign view.len       = len_r;
  assign view.match_all = match_all;
  assign view.overflow  = ovf_r;

endmodule

`default_nettype wire

### sv/wnm_match_core.sv
// Match core: bit-parallel update of the reachable mask positions per name byte.
`default_nettype none

module wnm_match_core (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                go,
  input  wire wnm_pkg::item_t      item,
  input  wire wnm_pkg::mask_view_t view,
  output logic                     matched
);
  import wnm_pkg::*;

  logic [POS_W-1:0]    act_r, act_nxt;
  logic                busy_r, busy_nxt;
  logic [POS_W-1:0]    cur;
  logic [MASK_LEN-1:0] live;
  logic [MASK_LEN-1:0] stay;
  logic [MASK_LEN-1:0] adv;
  logic [POS_W-1:0]    stepped;
  logic [POS_W-1:0]    prop;
  logic [POS_W:0]      carry_sum;
  logic [POS_W-1:0]    closed;
  logic [7:0]          name_chr;

  // A new name starts from the leading star run of the mask.
  assign cur      = busy_r ? act_r : view.start;
  assign name_chr = fold_letter(item.char_value);

  // Per-position transitions: a star keeps its position, a hit advances.
  always_comb begin
    for (int i = 0; i < MASK_LEN; i++) begin
      live[i] = cur[i] & view.in_mask[i];
      stay[i] = live[i] & view.star[i];
      adv[i]  = live[i] & ~view.star[i] &
                (view.qmark[i] | (view.chr[i] == name_chr));
    end
  end

  assign stepped = {adv, 1'b0} | {1'b0, stay};

  // Star closure: a carry runs from each reached star through its star run.
  assign prop      = {1'b0, view.star};
  assign carry_sum = {1'b0, stepped & prop} + {1'b0, prop};
  assign closed    = stepped | (carry_sum[POS_W-1:0] ^ prop);

  assign matched = view.match_all | closed[view.len];

  // Name tracking state.
  always_comb begin
    act_nxt  = act_r;
    busy_nxt = busy_r;
    if (go) begin
      unique case (item.action)
        ACT_CLEAR, ACT_APPEND: begin
          busy_nxt = 1'b0;
        end
        ACT_NAME: begin
          act_nxt  = closed;
          busy_nxt = ~item.last;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r  <= '0;
      busy_r <= 1'b0;
    end else begin
      act_r  <= act_nxt;
      busy_r <= busy_nxt;
    end
  end

endmodule

`default_nettype wire

### bench/wildcard_name_matcher_unit_tb.sv
// Self-checking testbench for the wildcard name matcher: directed cases, then random traffic.
module wildcard_name_matcher_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wnm_pkg::*;

  // Action code that the block must ignore.
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int RESULT_LATENCY = 1;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 500;
  localparam int MAX_REPORTS = 10;

  // Expected contents of one result beat.
  typedef struct packed {
    logic mask_overflow;
    logic matched;
  } verdict_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'd0;    // [7:0] char_value
  logic [1:0] in_tuser = 2'd0;    // [1:0] action
  logic       in_tlast = 1'b0;    // last
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;          // [0] matched, [1] mask_overflow, [7:2] zero

  // Shadow of the mask store and the match state.
  logic [7:0]       mask_bytes [MASK_LEN];
  int               mask_count = 0;
  logic [POS_W-1:0] reach = '0;
  bit               name_open = 1'b0;
  bit               dropped_seen = 1'b0;

  verdict_t pending_verdicts[$];
  int       fail_count = 0;
  int       items_sent = 0;
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;
  int       cycles = 0;

  wildcard_name_matcher_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // Free-running clock.
  initial begin
    forever #2 clk = ~clk;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic [7:0] lower_case(input logic [7:0] c);
    if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
      return c ^ CASE_OFFSET;
    end
    return c;
  endfunction

  // A reachable star also makes the position after it reachable.
  function automatic logic [POS_W-1:0] close_stars(input logic [POS_W-1:0] v);
    for (int i = 0; i < mask_count; i++) begin
      if (v[i] && mask_bytes[i] == CH_STAR) begin
        v[i+1] = 1'b1;
      end
    end
    return v;
  endfunction

  // Advance the shadow state by one accepted beat and queue any result it causes.
  task automatic predict_match(input logic [1:0] act, input logic [7:0] ch, input logic lst);
    logic [POS_W-1:0] nxt;
    bit               all_names;
    verdict_t         verdict;
    case (act)
      ACT_CLEAR: begin
        mask_count = 0;
        dropped_seen = 1'b0;
        name_open = 1'b0;
      end
      ACT_APPEND: begin
        if (mask_count < MASK_LEN) begin
          mask_bytes[mask_count] = ch;
          mask_count++;
        end else begin
          dropped_seen = 1'b1;
        end
        name_open = 1'b0;
      end
      ACT_NAME: begin
        if (!name_open) begin
          reach = close_stars(POS_W'(1));
          name_open = 1'b1;
        end
        nxt = '0;
        for (int i = 0; i < mask_count; i++) begin
          if (reach[i]) begin
            if (mask_bytes[i] == CH_STAR) begin
              nxt[i] = 1'b1;
            end else if (mask_bytes[i] == CH_QMARK ||
                         lower_case(mask_bytes[i]) == lower_case(ch)) begin
              nxt[i+1] = 1'b1;
            end
          end
        end
        reach = close_stars(nxt);
        if (lst) begin
          name_open = 1'b0;
          all_names = (mask_count == 0) ||
                      (mask_count == 3 && mask_bytes[0] == CH_STAR &&
                       mask_bytes[1] == CH_DOT && mask_bytes[2] == CH_STAR);
          verdict.mask_overflow = dropped_seen;
          verdict.matched       = all_names || reach[mask_count];
          pending_verdicts = {pending_verdicts, verdict};
        end
      end
      default: begin
      end
    endcase
  endtask

  // Drive one beat, with random idle cycles ahead of it, and wait for the handshake.
  task automatic send_beat(input logic [1:0] act, input logic [7:0] ch, input logic lst);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= ch;
    in_tlast  <= lst;
    @(posedge clk);
    while (!in_tready) begin
      @(posedge clk);
    end
    predict_match(act, ch, lst);
    if (act != ACT_UNUSED) begin
      items_sent++;
    end
  endtask

  // Stop sending until every expected result has arrived.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0) begin
      @(posedge clk);
    end
    repeat (RESULT_LATENCY + 2) @(posedge clk);
  endtask

  task automatic load_mask(input string pattern);
    send_beat(ACT_CLEAR, 8'($urandom), 1'($urandom));
    foreach (pattern[i]) begin
      send_beat(ACT_APPEND, pattern[i], 1'($urandom));
    end
  endtask

  task automatic send_name(input string text);
    foreach (text[i]) begin
      send_beat(ACT_NAME, text[i], i == text.len() - 1);
    end
  endtask

  // Result side: random stalls, and every beat taken is checked against the oldest verdict.
  always @(posedge clk) begin
    verdict_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (pending_verdicts.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS) begin
            $display("unexpected result beat: out_tdata=%h", out_tdata);
          end
        end else begin
          want = pending_verdicts.pop_front();
          if (out_tdata[0] !== want.matched || out_tdata[1] !== want.mask_overflow ||
              out_tdata[7:2] !== 6'd0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS) begin
              $display("result mismatch: expected matched=%b mask_overflow=%b, got %b %b pad=%b",
                       want.matched, want.mask_overflow, out_tdata[0], out_tdata[1],
                       out_tdata[7:2]);
            end
          end
        end
      end
      out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Empty mask and the exact mask "*.*" accept any name; "*.?" is matched normally.
  task automatic test_match_all_masks();
    send_beat(ACT_CLEAR, 8'hFF, 1'b1);
    send_name("Q");
    load_mask("*.*");
    send_name("noext");
    load_mask("*.?");
    send_name("noext");
    send_name("a.b");
    wait_drained();
  endtask

  // Question mark, stars, letter folding, and a star in the name.
  task automatic test_wildcards_and_case();
    load_mask("a?*Z");
    send_name("AbqqZ");
    send_name("abz");
    send_name("ab");
    load_mask("*b");
    send_name("*B");
    load_mask("a*");
    send_name("*");
    wait_drained();
  endtask

  // Zero bytes are ordinary; extremes of the byte range.
  task automatic test_zero_and_extreme_bytes();
    send_beat(ACT_CLEAR, 8'h00, 1'b0);
    send_beat(ACT_APPEND, 8'h00, 1'b0);
    send_beat(ACT_APPEND, CH_QMARK, 1'b1);
    send_beat(ACT_APPEND, 8'hFF, 1'b0);
    send_beat(ACT_NAME, 8'h00, 1'b0);
    send_beat(ACT_NAME, 8'h80, 1'b0);
    send_beat(ACT_NAME, 8'hFF, 1'b1);
    send_beat(ACT_NAME, 8'h01, 1'b0);
    send_beat(ACT_NAME, 8'h00, 1'b0);
    send_beat(ACT_NAME, 8'hFF, 1'b1);
    wait_drained();
  endtask

  // A mask edit abandons the name in progress without a result.
  task automatic test_mask_change_mid_name();
    load_mask("ab");
    send_beat(ACT_NAME, "a", 1'b0);
    send_beat(ACT_APPEND, "c", 1'b1);
    send_name("ABC");
    send_beat(ACT_NAME, "x", 1'b0);
    send_beat(ACT_CLEAR, 8'h00, 1'b0);
    send_name("z");
    wait_drained();
  endtask

  // Action 3 is dropped and leaves the name in progress alone.
  task automatic test_unused_action();
    load_mask("k?");
    send_beat(ACT_NAME, "K", 1'b0);
    send_beat(ACT_UNUSED, 8'hA5, 1'b1);
    send_beat(ACT_NAME, "7", 1'b1);
    wait_drained();
  endtask

  // Appends past capacity are dropped and flagged until the next clear.
  task automatic test_mask_overflow();
    send_beat(ACT_CLEAR, 8'h00, 1'b0);
    repeat (MASK_LEN - 1) send_beat(ACT_APPEND, CH_QMARK, 1'b0);
    send_beat(ACT_APPEND, "E", 1'b0);
    send_beat(ACT_APPEND, "x", 1'b0);
    send_beat(ACT_APPEND, CH_STAR, 1'b0);
    repeat (MASK_LEN - 1) send_beat(ACT_NAME, 8'($urandom), 1'b0);
    send_beat(ACT_NAME, "e", 1'b1);
    send_name("e");
    send_beat(ACT_CLEAR, 8'hFF, 1'b1);
    send_name("e");
    wait_drained();
  endtask

  function automatic logic [7:0] pick_letter();
    logic [7:0] c;
    c = 8'h61 + 8'($urandom_range(0, 25));
    if ($urandom_range(0, 1)) begin
      c = c ^ CASE_OFFSET;
    end
    return c;
  endfunction

  // Bytes weighted toward wildcards, dots and letters so that names often match.
  function automatic logic [7:0] pick_mask_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) begin
      return CH_STAR;
    end else if (r < 40) begin
      return CH_QMARK;
    end else if (r < 50) begin
      return CH_DOT;
    end else if (r < 85) begin
      return pick_letter();
    end
    return 8'($urandom);
  endfunction

  // Build a name that fits the mask, sometimes spoiled, sometimes wholly random.
  task automatic shape_name(ref logic [7:0] mask_q[$], ref logic [7:0] name_q[$]);
    logic [7:0] c;
    name_q.delete();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 6)) name_q = {name_q, 8'($urandom)};
    end else begin
      foreach (mask_q[i]) begin
        c = mask_q[i];
        if (c == CH_STAR) begin
          repeat ($urandom_range(0, 3)) name_q = {name_q, pick_mask_byte()};
        end else if (c == CH_QMARK) begin
          name_q = {name_q, 8'($urandom)};
        end else begin
          if ((c | CASE_OFFSET) >= "a" && (c | CASE_OFFSET) <= "z" && $urandom_range(0, 1)) begin
            c = c ^ CASE_OFFSET;
          end
          name_q = {name_q, c};
        end
      end
      if ($urandom_range(0, 3) == 0 && name_q.size() > 0) begin
        name_q[$urandom_range(0, name_q.size() - 1)] = 8'($urandom);
      end
    end
    if (name_q.size() == 0) begin
      name_q = {name_q, pick_mask_byte()};
    end
  endtask

  // Mostly well-formed mask loads followed by names; some noise and broken names.
  task automatic run_random(input int goal);
    logic [7:0] mask_q[$];
    logic [7:0] name_q[$];
    int         r;
    int         n;
    while (items_sent < goal) begin
      r = $urandom_range(0, 99);
      if (r < 80) begin
        if (mask_q.size() == 0 || $urandom_range(0, 2) == 0) begin
          mask_q.delete();
          n = ($urandom_range(0, 9) == 0) ? $urandom_range(MASK_LEN - 4, MASK_LEN + 4)
                                          : $urandom_range(0, 8);
          repeat (n) mask_q = {mask_q, pick_mask_byte()};
          send_beat(ACT_CLEAR, 8'($urandom), 1'($urandom));
          foreach (mask_q[i]) begin
            send_beat(ACT_APPEND, mask_q[i], 1'($urandom));
          end
        end
        repeat ($urandom_range(1, 4)) begin
          shape_name(mask_q, name_q);
          foreach (name_q[i]) begin
            send_beat(ACT_NAME, name_q[i], i == name_q.size() - 1);
          end
        end
      end else if (r < 90) begin
        send_beat(2'($urandom), 8'($urandom), 1'($urandom));
      end else begin
        // Partial name cut short by a mask edit.
        repeat ($urandom_range(1, 3)) send_beat(ACT_NAME, pick_mask_byte(), 1'b0);
        if ($urandom_range(0, 1)) begin
          mask_q = {mask_q, pick_mask_byte()};
          send_beat(ACT_APPEND, mask_q[$], 1'($urandom));
        end else begin
          mask_q.delete();
          send_beat(ACT_CLEAR, 8'($urandom), 1'($urandom));
        end
      end
    end
  endtask

  // Test sequence.
  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_match_all_masks();
    test_wildcards_and_case();
    test_zero_and_extreme_bytes();
    test_mask_change_mid_name();
    test_unused_action();
    test_mask_overflow();

    send_idle_pct = 0;
    recv_stall_pct = 0;
    run_random(items_sent + RANDOM_ITEMS / 4);
    wait_drained();
    send_idle_pct = 73;
    recv_stall_pct = 0;
    run_random(items_sent + RANDOM_ITEMS / 4);
    send_idle_pct = 0;
    recv_stall_pct = 73;
    run_random(items_sent + RANDOM_ITEMS / 4);
    send_idle_pct = 31;
    recv_stall_pct = 31;
    run_random(items_sent + RANDOM_ITEMS / 4);
    wait_drained();

    if (fail_count == 0 && pending_verdicts.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+sv
sv/wnm_pkg.sv
sv/wnm_mask_store.sv
sv/wnm_match_core.sv
sv/wildcard_name_matcher_unit.sv
bench/wildcard_name_matcher_unit_tb.sv
